// File: rtl/bfss_pkg.sv
// ----------------------------------------------------------------------------
// bfss_pkg
// Shared types and constants of the string-set Bloom filter: the hash
// multipliers, the index scramble key and the header of a probe job.
// ----------------------------------------------------------------------------
package bfss_pkg;

    // Width of the hash-count register.
    localparam int unsigned NUM_W = 4;

    // Reset value of the hash-count register.
    localparam logic [NUM_W-1:0] NUM_HASHES_RESET = 4'd5;

    // Prime multipliers; hash k uses entry (MAX_HASHES - 1 - k).
    localparam int unsigned TABLE_DEPTH = 9;
    localparam logic [23:0] MULT_TABLE [TABLE_DEPTH] = '{
        24'd9999901, 24'd9999907, 24'd9999929, 24'd9999931, 24'd9999937,
        24'd9999943, 24'd9999971, 24'd9999973, 24'd9999991
    };

    // Key that scrambles each finished code into a bit index.
    localparam logic [23:0] XOR_KEY = 24'd9999901;

    // Mode codes.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // Header of one finished string handed to the probe engine.
    typedef struct packed {
        logic             mode;
        logic [NUM_W-1:0] used;
    } bfss_hdr_t;

endpackage

// File: rtl/bfss_front.sv
// ----------------------------------------------------------------------------
// bfss_front
// Accepts characters, keeps one running polynomial code per hash lane and
// emits a probe job with the scrambled bit indices at the end of a string.
// ----------------------------------------------------------------------------
module bfss_front #(
    parameter int unsigned INDEX_BITS = 20,
    parameter int unsigned MAX_HASHES = 9
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       cfg_wr_en,
    input  logic [bfss_pkg::NUM_W-1:0]                 cfg_wr_data,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic                                       in_mode,
    input  logic signed [7:0]                          in_char,
    input  logic                                       in_last,
    input  logic                                       q_full,
    input  logic                                       clearing,
    output logic                                       push,
    output bfss_pkg::bfss_hdr_t                        job_hdr,
    output logic [MAX_HASHES-1:0][INDEX_BITS-1:0]      job_idx
);
    import bfss_pkg::*;

    localparam logic [INDEX_BITS-1:0] KEY_N = INDEX_BITS'(XOR_KEY);

    logic [NUM_W-1:0]      num_hashes_reg;
    logic                  accept;
    logic [INDEX_BITS-1:0] ch_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_hashes_reg <= NUM_HASHES_RESET;
        end else if (cfg_wr_en) begin
            num_hashes_reg <= cfg_wr_data;
        end
    end

    // Every character waits for a queue slot; the bit store must be cleared first.
    assign in_ready = !q_full && !clearing;
    assign accept   = in_valid && in_ready;
    assign push     = accept && in_last;
    assign ch_ext   = INDEX_BITS'(in_char);

    always_comb begin
        job_hdr.mode = in_mode;
        if (num_hashes_reg > NUM_W'(MAX_HASHES)) begin
            job_hdr.used = NUM_W'(MAX_HASHES);
        end else begin
            job_hdr.used = num_hashes_reg;
        end
    end

    for (genvar k = 0; k < MAX_HASHES; k++) begin : g_lane
        localparam logic [INDEX_BITS-1:0] PRIME =
            INDEX_BITS'(MULT_TABLE[MAX_HASHES-1-k]);

        logic [INDEX_BITS-1:0] code_reg;
        logic [INDEX_BITS-1:0] power_reg;
        logic [INDEX_BITS-1:0] code_next;
        logic [INDEX_BITS-1:0] power_next;

        // Arithmetic wraps at the index width, which is all the index uses.
        assign code_next  = code_reg + power_reg * ch_ext;
        assign power_next = power_reg * PRIME;
        assign job_idx[k] = code_next ^ KEY_N;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                code_reg  <= '0;
                power_reg <= INDEX_BITS'(1);
            end else if (accept) begin
                if (in_last) begin
                    code_reg  <= '0;
                    power_reg <= INDEX_BITS'(1);
                end else begin
                    code_reg  <= code_next;
                    power_reg <= power_next;
                end
            end
        end
    end

endmodule

// File: rtl/bfss_queue.sv
// ----------------------------------------------------------------------------
// bfss_queue
// Two-entry register queue of probe jobs between the hashing front end and
// the probe engine.
// ----------------------------------------------------------------------------
module bfss_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: rtl/bfss_back.sv
// ----------------------------------------------------------------------------
// bfss_back
// Probe engine: owns the filter bit store, clears it after reset, sets or
// tests one bit per cycle for each queued job and holds the result.
// ----------------------------------------------------------------------------
module bfss_back #(
    parameter int unsigned INDEX_BITS = 20,
    parameter int unsigned MAX_HASHES = 9
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  job_valid,
    input  bfss_pkg::bfss_hdr_t                   job_hdr,
    input  logic [MAX_HASHES-1:0][INDEX_BITS-1:0] job_idx,
    output logic                                  pop,
    output logic                                  clearing,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_found,
    output logic                                  m_was_query
);
    import bfss_pkg::*;

    logic                                  filter_mem [2**INDEX_BITS];
    logic                                  rd_data_reg;

    logic                                  clr_active_reg;
    logic [INDEX_BITS-1:0]                 clr_addr_reg;

    logic                                  busy_reg,    busy_next;
    logic [NUM_W-1:0]                      rem_reg,     rem_next;
    logic                                  mode_reg,    mode_next;
    logic                                  found_reg,   found_next;
    logic                                  rd_pend_reg, rd_pend_next;
    logic [MAX_HASHES-1:0][INDEX_BITS-1:0] idx_sh_reg,  idx_sh_next;
    logic                                  out_valid_reg, out_valid_next;
    logic                                  out_found_reg, out_found_next;
    logic                                  out_query_reg, out_query_next;

    logic                                  probe;
    logic                                  mem_we;
    logic [INDEX_BITS-1:0]                 mem_wa;
    logic                                  mem_wd;

    assign clearing    = clr_active_reg;
    assign m_valid     = out_valid_reg;
    assign m_found     = out_found_reg;
    assign m_was_query = out_query_reg;

    assign pop   = !busy_reg && job_valid && !clr_active_reg;
    assign probe = busy_reg && (rem_reg != '0);

    assign mem_we = clr_active_reg || (probe && (mode_reg == MODE_INSERT));
    assign mem_wa = clr_active_reg ? clr_addr_reg : idx_sh_reg[0];
    assign mem_wd = !clr_active_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            filter_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= filter_mem[idx_sh_reg[0]];
    end

    // One entry per cycle after reset; no request is taken until it ends.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + INDEX_BITS'(1);
            if (&clr_addr_reg) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        busy_next      = busy_reg;
        rem_next       = rem_reg;
        mode_next      = mode_reg;
        found_next     = found_reg;
        rd_pend_next   = 1'b0;
        idx_sh_next    = idx_sh_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_found_next = out_found_reg;
        out_query_next = out_query_reg;

        // A query read issued last cycle lands now.
        if (rd_pend_reg) begin
            found_next = found_reg && rd_data_reg;
        end

        if (pop) begin
            busy_next   = 1'b1;
            rem_next    = job_hdr.used;
            mode_next   = job_hdr.mode;
            found_next  = 1'b1;
            idx_sh_next = job_idx;
        end else if (probe) begin
            rem_next     = rem_reg - NUM_W'(1);
            rd_pend_next = (mode_reg == MODE_QUERY);
            for (int i = 0; i < MAX_HASHES - 1; i++) begin
                idx_sh_next[i] = idx_sh_reg[i+1];
            end
        end else if (busy_reg && !rd_pend_reg && (!out_valid_reg || m_ready)) begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            out_found_next = (mode_reg == MODE_QUERY) && found_reg;
            out_query_next = mode_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg       <= rem_next;
        mode_reg      <= mode_next;
        found_reg     <= found_next;
        idx_sh_reg    <= idx_sh_next;
        out_found_reg <= out_found_next;
        out_query_reg <= out_query_next;
    end

endmodule

// File: rtl/bloom_filter_string_set.sv
// ----------------------------------------------------------------------------
// bloom_filter_string_set
// Bloom filter over strings streamed one character per request.
// ----------------------------------------------------------------------------
// Characters are taken at one per cycle while the queue has room and the
// bit store is not being cleared; each one advances all MAX_HASHES
// polynomial hash lanes (nine by default) in that cycle. The request that
// ends a string (tlast) hands the finished indices to a two-entry queue,
// and the probe engine then takes the job, sets or tests one bit of the
// bit store per active hash and raises the result, a query once its last
// read has landed. The number of active hashes is num_hashes capped at
// MAX_HASHES. A result (tdata bit 0 found, tuser was_query) is produced
// only for the last character of a string. After reset the bit store is
// cleared one bit per cycle, and no character is accepted until that pass
// ends; the hash-count register may be written meanwhile.
module bloom_filter_string_set #(
    parameter int unsigned INDEX_BITS = 20,
    parameter int unsigned MAX_HASHES = 9
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [bfss_pkg::NUM_W-1:0] cfg_wr_data,   // num_hashes
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,  // [7:0] char_byte
    input  logic                       s_axis_tuser,  // [0] mode
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,  // [0] found, [7:1] zero
    output logic                       m_axis_tuser   // [0] was_query
);
    import bfss_pkg::*;

    localparam int unsigned HDR_W = $bits(bfss_hdr_t);
    localparam int unsigned JOB_W = HDR_W + MAX_HASHES * INDEX_BITS;

    logic                                  q_full;
    logic                                  q_not_empty;
    logic                                  push;
    logic                                  pop;
    logic                                  clearing;
    logic                                  found;
    bfss_hdr_t                             front_hdr;
    logic [MAX_HASHES-1:0][INDEX_BITS-1:0] front_idx;
    logic [JOB_W-1:0]                      q_out;
    bfss_hdr_t                             back_hdr;
    logic [MAX_HASHES-1:0][INDEX_BITS-1:0] back_idx;

    bfss_front #(
        .INDEX_BITS (INDEX_BITS),
        .MAX_HASHES (MAX_HASHES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_mode     (s_axis_tuser),
        .in_char     (signed'(s_axis_tdata)),
        .in_last     (s_axis_tlast),
        .q_full      (q_full),
        .clearing    (clearing),
        .push        (push),
        .job_hdr     (front_hdr),
        .job_idx     (front_idx)
    );

    bfss_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({front_hdr, front_idx}),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    assign back_hdr = q_out[JOB_W-1 -: HDR_W];
    assign back_idx = q_out[JOB_W-HDR_W-1:0];

    bfss_back #(
        .INDEX_BITS (INDEX_BITS),
        .MAX_HASHES (MAX_HASHES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (q_not_empty),
        .job_hdr     (back_hdr),
        .job_idx     (back_idx),
        .pop         (pop),
        .clearing    (clearing),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_found     (found),
        .m_was_query (m_axis_tuser)
    );

    assign m_axis_tdata = {7'b0, found};

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the string-set Bloom filter against a bit-exact model kept in the
// testbench. Characters are streamed in with random gaps, and every finished
// string is hashed, probed and checked against the result that comes back.
// A short directed part covers the extreme characters, both modes, a mode
// change inside a string, zero characters and the edge hash counts. Several
// random phases follow, each with its own hash count.
// ----------------------------------------------------------------------------
module tb_top;
    import bfss_pkg::*;

    localparam int unsigned IDX_W      = 20;
    localparam int unsigned LANES      = 9;
    localparam int unsigned CYCLE_CAP  = 4_000_000;
    localparam int unsigned PROBE_TAIL = 20;

    typedef struct packed {
        logic found;
        logic was_query;
    } verdict_t;

    logic             aclk;
    logic             aresetn       = 1'b0;
    logic             cfg_wr_en     = 1'b0;
    logic [NUM_W-1:0] cfg_wr_data   = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata  = '0;
    logic             s_axis_tuser  = 1'b0;
    logic             s_axis_tlast  = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [7:0]       m_axis_tdata;
    logic             m_axis_tuser;

    // Model state: one running code and power per hash lane, and the bit store.
    logic [IDX_W-1:0] lane_code [LANES];
    logic [IDX_W-1:0] lane_power [LANES];
    bit               filter_set [1 << IDX_W];
    logic [NUM_W-1:0] hash_count;

    verdict_t         pending_verdicts [$];
    logic [159:0]     stored_text [$];
    int               stored_len [$];
    int               chars_sent  = 0;
    int               fail_count  = 0;
    int unsigned      cycle_count = 0;
    bit               steady      = 1'b0;

    bloom_filter_string_set #(
        .INDEX_BITS (IDX_W),
        .MAX_HASHES (LANES)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 11);
    end

    function automatic void restart_lanes();
        for (int k = 0; k < LANES; k++) begin
            lane_code[k]  = '0;
            lane_power[k] = IDX_W'(1);
        end
    endfunction

    // Folds one character into every lane and, on the last character of a
    // string, probes or sets the filter and queues the expected verdict.
    function automatic void hash_and_probe(logic md, logic [7:0] ch, logic lst);
        logic [IDX_W-1:0] wide_ch;
        logic [IDX_W-1:0] idx;
        int unsigned      used;
        logic             hit;
        verdict_t         v;
        wide_ch = {{(IDX_W-8){ch[7]}}, ch};
        for (int k = 0; k < LANES; k++) begin
            lane_code[k]  = lane_code[k] + lane_power[k] * wide_ch;
            lane_power[k] = lane_power[k] * MULT_TABLE[LANES-1-k][IDX_W-1:0];
        end
        if (!lst) return;
        used = (hash_count > LANES) ? LANES : hash_count;
        hit  = 1'b1;
        for (int k = 0; k < used; k++) begin
            idx = lane_code[k] ^ XOR_KEY[IDX_W-1:0];
            if (md == MODE_INSERT) filter_set[idx] = 1'b1;
            else if (!filter_set[idx]) hit = 1'b0;
        end
        v.found     = (md == MODE_QUERY) ? hit : 1'b0;
        v.was_query = md;
        pending_verdicts.push_back(v);
        restart_lanes();
    endfunction

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result found=%0b was_query=%0b with no request outstanding",
                         $time, m_axis_tdata[0], m_axis_tuser);
                fail_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_axis_tdata[0] !== want.found) begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, m_axis_tdata[0]);
                    fail_count++;
                end
                if (m_axis_tuser !== want.was_query) begin
                    $display("%0t: was_query expected %0b actual %0b",
                             $time, want.was_query, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Entered and left at a falling edge; tvalid is left high, and a random gap may drop it before a request.
    task automatic send_char(input logic md, input logic [7:0] ch, input logic lst);
        if (!steady && $urandom_range(99) < 11) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= md;
        s_axis_tlast  <= lst;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        hash_and_probe(md, ch, lst);
        chars_sent++;
        @(negedge aclk);
    endtask

    // Characters go lowest byte first; a mixed string takes random modes
    // on every character but the last.
    task automatic send_string(input logic [159:0] text, input int len, input logic md,
                               input bit mixed);
        logic m;
        for (int i = 0; i < len; i++) begin
            m = (i == len - 1 || !mixed) ? md : logic'($urandom_range(1));
            send_char(m, text[8*i +: 8], i == len - 1);
        end
    endtask

    // Waits for every outstanding result, then lets the probe engine finish.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(negedge aclk);
        repeat (PROBE_TAIL) @(negedge aclk);
    endtask

    task automatic write_hash_count(input logic [NUM_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        hash_count  = value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [159:0] random_text();
        logic [159:0] t;
        logic [7:0]   c;
        for (int i = 0; i < 20; i++) begin
            case ($urandom_range(9))
                0: c = 8'h00;
                1: c = 8'h80;
                2: c = 8'h7F;
                3: c = 8'hFF;
                default: c = 8'($urandom);
            endcase
            t[8*i +: 8] = c;
        end
        return t;
    endfunction

    task automatic pick_string();
        logic [159:0] text;
        int           len;
        int           r;
        int           slot;
        r    = $urandom_range(99);
        len  = ($urandom_range(19) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
        text = random_text();
        if (r < 35 || stored_text.size() == 0) begin
            send_string(text, len, MODE_INSERT, 1'b0);
            stored_text.push_back(text);
            stored_len.push_back(len);
            if (stored_text.size() > 64) begin
                void'(stored_text.pop_front());
                void'(stored_len.pop_front());
            end
        end else if (r < 70) begin
            slot = $urandom_range(stored_text.size() - 1);
            send_string(stored_text[slot], stored_len[slot], MODE_QUERY, 1'b0);
        end else if (r < 80) begin
            slot = $urandom_range(stored_text.size() - 1);
            send_string(stored_text[slot], stored_len[slot], MODE_INSERT, 1'b1);
        end else if (r < 92) begin
            send_string(text, len, MODE_QUERY, 1'b0);
        end else begin
            send_string(text, len, logic'($urandom_range(1)), 1'b1);
        end
    endtask

    // The hash count still holds its reset value here, and the store is empty.
    task automatic test_reset_state();
        send_string(160'h41, 1, MODE_QUERY, 1'b0);
        settle();
    endtask

    task automatic test_extreme_chars();
        send_string(160'h01_00_7F_80, 4, MODE_INSERT, 1'b0);
        send_string(160'h01_00_7F_80, 4, MODE_QUERY, 1'b0);
        send_string(160'h80_7F, 2, MODE_QUERY, 1'b0);
        settle();
    endtask

    // Only the mode of the character that ends the string should count.
    task automatic test_mode_switch();
        send_char(MODE_QUERY, 8'h55, 1'b0);
        send_char(MODE_QUERY, 8'hAA, 1'b0);
        send_char(MODE_INSERT, 8'h00, 1'b1);
        send_char(MODE_INSERT, 8'h55, 1'b0);
        send_char(MODE_INSERT, 8'hAA, 1'b0);
        send_char(MODE_QUERY, 8'h00, 1'b1);
        settle();
    endtask

    // A zero still advances the power, yet leaves the code unchanged, so a
    // run of zeros hashes the same as a single zero.
    task automatic test_zero_chars();
        send_string(160'h00_00, 2, MODE_INSERT, 1'b0);
        send_string(160'h00, 1, MODE_QUERY, 1'b0);
        settle();
    endtask

    task automatic test_no_hashes();
        write_hash_count(4'd0);
        send_string(160'h80_7F, 2, MODE_QUERY, 1'b0);
        send_string(160'h12, 1, MODE_INSERT, 1'b0);
        settle();
    endtask

    task automatic test_saturated_count();
        write_hash_count(4'd15);
        send_string(160'h33, 1, MODE_INSERT, 1'b0);
        send_string(160'h33, 1, MODE_QUERY, 1'b0);
        send_string(160'h34, 1, MODE_QUERY, 1'b0);
        settle();
    endtask

    task automatic test_random_phase(input logic [NUM_W-1:0] setting, input int budget,
                                     input bit calm);
        int start;
        start = chars_sent;
        write_hash_count(setting);
        steady = calm;
        while (chars_sent - start < budget) pick_string();
        steady = 1'b0;
        settle();
    endtask

    initial begin
        restart_lanes();
        hash_count = NUM_HASHES_RESET;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_extreme_chars();
        test_mode_switch();
        test_zero_chars();
        test_no_hashes();
        test_saturated_count();

        test_random_phase(4'd1, 92, 1'b0);
        test_random_phase(4'd9, 92, 1'b1);
        test_random_phase(4'd0, 92, 1'b0);
        test_random_phase(4'd15, 92, 1'b0);
        test_random_phase(4'd2, 92, 1'b0);
        test_random_phase(4'd5, 92, 1'b0);
        test_random_phase(4'($urandom_range(15)), 92, 1'b0);
        test_random_phase(4'd7, 92, 1'b0);

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
